@@ rtl/gcd_lcm_unit_defines.svh @@
// assertion macros shared by the gcd/lcm unit
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define GLU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every clock edge, reset included
`define GLU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GLU_ASSERT(label, clk, rst, prop, msg)
`define GLU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/glu_pkg.sv @@
`timescale 1ns / 1ps

package glu_pkg;

   // operand width used inside the unit, field widths on the ports
   localparam int OPERAND_BITS  = 16;
   localparam int FIELD_BITS    = 16;
   localparam int DIVISOR_BITS  = 16;
   localparam int MULTIPLE_BITS = 32;
   // product register, at least as wide as the multiple field
   localparam int PROD_BITS = (2 * OPERAND_BITS > MULTIPLE_BITS) ?
                              2 * OPERAND_BITS : MULTIPLE_BITS;
   localparam int CNT_BITS  = $clog2(OPERAND_BITS);

   typedef struct packed {
      logic [FIELD_BITS-1:0] operand_a;
      logic [FIELD_BITS-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [DIVISOR_BITS-1:0]  divisor;
      logic [MULTIPLE_BITS-1:0] multiple;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REM,
      ST_EVAL,
      ST_QUO,
      ST_MUL_LOAD,
      ST_MUL,
      ST_FINAL,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ALU_HOLD,
      ALU_LOAD_DIV,
      ALU_STEP_DIV,
      ALU_LOAD_MUL,
      ALU_STEP_MUL
   } alu_op_type;

   // command from the sequencer to the arithmetic unit
   typedef struct packed {
      alu_op_type              op;
      logic [OPERAND_BITS-1:0] lhs;
      logic [OPERAND_BITS-1:0] rhs;
   } alu_cmd_type;

   // register contents of the arithmetic unit
   typedef struct packed {
      logic [OPERAND_BITS-1:0] quotient;
      logic [OPERAND_BITS-1:0] remainder;
      logic [PROD_BITS-1:0]    product;
   } alu_res_type;

   // clamp the product to the multiple field
   function automatic logic [MULTIPLE_BITS-1:0] sat_multiple(input logic [PROD_BITS-1:0] p);
      logic [PROD_BITS-1:0] high;
      high = p >> MULTIPLE_BITS;
      if (high != '0) begin
         return '1;
      end
      return MULTIPLE_BITS'(p);
   endfunction

endpackage

@@ rtl/glu_alu.sv @@
`timescale 1ns / 1ps
`include "gcd_lcm_unit_defines.svh"

module glu_alu (
   input  logic                 clock,
   input  glu_pkg::alu_cmd_type cmd,
   output glu_pkg::alu_res_type res
);
   import glu_pkg::*;

   localparam int OB = OPERAND_BITS;
   localparam int PW = PROD_BITS;

   logic [OB-1:0] rem_ff, rem_in;
   logic [OB-1:0] quo_ff, quo_in;
   logic [OB-1:0] den_ff, den_in;
   logic [OB-1:0] mplier_ff, mplier_in;
   logic [PW-1:0] mcand_ff, mcand_in;
   logic [PW-1:0] prod_ff, prod_in;

   logic [OB:0]   partial;
   logic [PW-1:0] add_x;
   logic [PW-1:0] add_y;
   logic          carry_in;
   logic [PW:0]   sum;

   // shared adder: trial subtract for division, accumulate for multiply
   always_comb begin
      partial  = {rem_ff, quo_ff[OB-1]};
      add_x    = prod_ff;
      add_y    = mplier_ff[0] ? mcand_ff : '0;
      carry_in = 1'b0;
      if (cmd.op == ALU_STEP_DIV) begin
         add_x    = PW'(partial);
         add_y    = ~PW'(den_ff);
         carry_in = 1'b1;
      end
      sum = {1'b0, add_x} + {1'b0, add_y} + (PW + 1)'(carry_in);
   end

   // one restoring-division bit or one multiply bit per cycle
   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      case (cmd.op)
         ALU_LOAD_DIV: begin
            rem_in = '0;
            quo_in = cmd.lhs;
            den_in = cmd.rhs;
         end
         ALU_STEP_DIV: begin
            // carry out set means no borrow: partial remainder covers divisor
            if (sum[PW]) begin
               rem_in = sum[OB-1:0];
               quo_in = {quo_ff[OB-2:0], 1'b1};
            end else begin
               rem_in = partial[OB-1:0];
               quo_in = {quo_ff[OB-2:0], 1'b0};
            end
         end
         ALU_LOAD_MUL: begin
            mcand_in  = PW'(cmd.lhs);
            mplier_in = cmd.rhs;
            prod_in   = '0;
         end
         ALU_STEP_MUL: begin
            prod_in   = sum[PW-1:0];
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
   end

   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;
   assign res.product   = prod_ff;

   `GLU_ASSERT_ALWAYS(a_mul_load_clears, clock, (cmd.op == ALU_LOAD_MUL) |=> (res.product == '0), "product not cleared on multiply load")
   `GLU_ASSERT_ALWAYS(a_div_rem_below_den, clock, (cmd.op == ALU_STEP_DIV && den_ff != '0) |=> (rem_ff < den_ff), "partial remainder not below divisor")

endmodule

@@ rtl/glu_ctrl.sv @@
`timescale 1ns / 1ps
`include "gcd_lcm_unit_defines.svh"

module glu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  glu_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output glu_pkg::rsp_type     rsp_data,
   output glu_pkg::alu_cmd_type cmd,
   input  glu_pkg::alu_res_type res
);
   import glu_pkg::*;

   localparam int OB = OPERAND_BITS;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [OB-1:0]           a_ff, a_in;
   logic [OB-1:0]           b_ff, b_in;
   logic [OB-1:0]           small_ff, small_in;
   logic [OB-1:0]           gcd_ff, gcd_in;
   logic [MULTIPLE_BITS-1:0] mult_ff, mult_in;

   logic [OB-1:0] op_a;
   logic [OB-1:0] op_b;
   logic [OB-1:0] big;
   logic [OB-1:0] lesser;

   // operands at the unit width, ordered for the first remainder
   always_comb begin
      op_a   = OB'(req_data.operand_a);
      op_b   = OB'(req_data.operand_b);
      big    = (op_b > op_a) ? op_b : op_a;
      lesser = (op_b > op_a) ? op_a : op_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      small_ff <= small_in;
      gcd_ff   <= gcd_in;
      mult_ff  <= mult_in;
   end

   // sequencer: euclid remainders, then a/gcd, then (a/gcd)*b; a zero operand goes straight to done
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      small_in  = small_ff;
      gcd_in    = gcd_ff;
      mult_in   = mult_ff;
      cmd.op    = ALU_HOLD;
      cmd.lhs   = '0;
      cmd.rhs   = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               a_in = op_a;
               b_in = op_b;
               if (lesser == '0) begin
                  // an operand is zero: divisor is the other, multiple zero
                  gcd_in   = big;
                  mult_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  cmd.op   = ALU_LOAD_DIV;
                  cmd.lhs  = big;
                  cmd.rhs  = lesser;
                  small_in = lesser;
                  cnt_in   = CNT_BITS'(OB - 1);
                  state_in = ST_REM;
               end
            end
         end
         ST_REM: begin
            cmd.op = ALU_STEP_DIV;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (res.remainder == '0) begin
               // last divisor is the gcd; start a / gcd
               gcd_in   = small_ff;
               cmd.op   = ALU_LOAD_DIV;
               cmd.lhs  = a_ff;
               cmd.rhs  = small_ff;
               state_in = ST_QUO;
            end else begin
               cmd.op   = ALU_LOAD_DIV;
               cmd.lhs  = small_ff;
               cmd.rhs  = res.remainder;
               small_in = res.remainder;
               state_in = ST_REM;
            end
            cnt_in = CNT_BITS'(OB - 1);
         end
         ST_QUO: begin
            cmd.op = ALU_STEP_DIV;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MUL_LOAD;
            end
         end
         ST_MUL_LOAD: begin
            cmd.op   = ALU_LOAD_MUL;
            cmd.lhs  = res.quotient;
            cmd.rhs  = b_ff;
            cnt_in   = CNT_BITS'(OB - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op = ALU_STEP_MUL;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            mult_in  = sat_multiple(res.product);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_data.divisor  = DIVISOR_BITS'(gcd_ff);
   assign rsp_data.multiple = mult_ff;

   `GLU_ASSERT(a_one_item_at_a_time, clock, reset,
      !(req_ready && rsp_valid),
      "input taken while a result is pending")
   `GLU_ASSERT(a_ready_after_rsp, clock, reset,
      (rsp_valid && rsp_ready) |=> req_ready,
      "not ready after result transfer")
   `GLU_ASSERT(a_zero_operand_fast, clock, reset,
      (req_valid && req_ready && (op_a == '0 || op_b == '0)) |=>
         (rsp_valid && rsp_data.multiple == '0),
      "zero operand result wrong or late")
   `GLU_ASSERT(a_zero_gcd_zero_lcm, clock, reset,
      (rsp_valid && gcd_ff == '0) |-> (mult_ff == '0),
      "zero divisor with nonzero multiple")

endmodule

@@ rtl/gcd_lcm_unit.sv @@
`timescale 1ns / 1ps
// an operand of zero: the result is valid in the cycle after the input transfer;
//   otherwise one bit-serial division per euclid remainder step (at most 22 at 16 bits),
//   then the a/gcd division and the multiply, in the bit-serial unit, one bit per cycle
// throughput: one item at a time; the next input is taken the cycle after a result transfer
// reset: synchronous, active high, returns the sequencer to idle; no clearing pass

module gcd_lcm_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  glu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output glu_pkg::rsp_type rsp_data
);
   import glu_pkg::*;

   alu_cmd_type alu_cmd;
   alu_res_type alu_res;

   // sequencer and output register
   glu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (alu_cmd),
      .res       (alu_res)
   );

   // shared shift/add/subtract unit
   glu_alu u_alu (
      .clock (clock),
      .cmd   (alu_cmd),
      .res   (alu_res)
   );

endmodule

@@ dv/gcd_lcm_unit_tb.sv @@
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;
   import glu_pkg::*;

   localparam int RANDOM_PAIRS = 850;
   localparam int QUIET_TAIL   = 100;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLDOFF_LEN  = 400;
   localparam int HOLDOFF_AT   = 300;
   localparam int DRAIN_WAIT   = 450;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_pairs[$];
   rsp_type expected_results[$];

   int pairs_total  = 0;
   int pairs_sent   = 0;
   int results_seen = 0;
   int errors       = 0;
   int req_gap      = 0;
   int rsp_stall    = 0;
   int holdoff_left = 0;
   int quiet_cycles = 0;
   bit holdoff_done = 1'b0;

   gcd_lcm_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // euclid on masked operands, lcm as (a / g) * b clamped to the field
   function automatic rsp_type predict_gcd_lcm(req_type pair);
      logic [63:0] mask;
      logic [63:0] a, b, big, sml, rest, lcm;
      rsp_type     r;
      mask = (OPERAND_BITS >= 64) ? '1 : (64'd1 << OPERAND_BITS) - 64'd1;
      a = 64'(pair.operand_a) & mask;
      b = 64'(pair.operand_b) & mask;
      big = (b > a) ? b : a;
      sml = (b > a) ? a : b;
      while (sml != 0) begin
         rest = big % sml;
         big  = sml;
         sml  = rest;
      end
      lcm = 64'd0;
      if (a != 0 && b != 0) begin
         lcm = (a / big) * b;
         if (lcm > 64'hFFFF_FFFF) begin
            lcm = 64'hFFFF_FFFF;
         end
      end
      r.divisor  = big[DIVISOR_BITS-1:0];
      r.multiple = lcm[MULTIPLE_BITS-1:0];
      return r;
   endfunction

   task automatic add_pair(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b);
      req_type p;
      p.operand_a = a;
      p.operand_b = b;
      pending_pairs.push_back(p);
      pairs_total++;
   endtask

   // no idling in every third stretch of 64 transfers and in the tail
   function automatic bit calm_phase(int count);
      return ((count / 64) % 3 == 2) || (count >= pairs_total - QUIET_TAIL);
   endfunction

   // driver: offers pending pairs, holds them until the transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_gcd_lcm(req_data));
            pairs_sent++;
         end
         if (req_valid && !req_ready) begin
            // payload stays put until taken
         end else if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm_phase(pairs_sent) && $urandom_range(0, 5) == 0) begin
            req_gap   <= $urandom_range(1, 14) - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_pairs.pop_front();
         end
      end
   end

   // monitor: checks each result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result divisor=%h multiple=%h",
                        $time, rsp_data.divisor, rsp_data.multiple);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.divisor !== want.divisor) begin
                  $display("%0t: divisor expected %h actual %h",
                           $time, want.divisor, rsp_data.divisor);
                  errors++;
               end
               if (rsp_data.multiple !== want.multiple) begin
                  $display("%0t: multiple expected %h actual %h",
                           $time, want.multiple, rsp_data.multiple);
                  errors++;
               end
            end
            results_seen++;
         end
         // one long hold-off so the unit backs up its input
         if (!holdoff_done && results_seen == HOLDOFF_AT) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_LEN - 1;
            rsp_ready    <= 1'b0;
         end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            rsp_ready    <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else if (!calm_phase(results_seen) && $urandom_range(0, 4) == 0) begin
            rsp_stall <= $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("gcd_lcm_unit_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      logic [FIELD_BITS-1:0] fib[$];
      logic [FIELD_BITS-1:0] a, b, g;
      int kind, i;

      // directed: zeros, extremes, equal, divisible, worst-case euclid
      add_pair(16'h0000, 16'h0000);
      add_pair(16'h0000, 16'h1234);
      add_pair(16'hBEEF, 16'h0000);
      add_pair(16'h0000, 16'hFFFF);
      add_pair(16'hFFFF, 16'h0000);
      add_pair(16'hFFFF, 16'hFFFF);
      add_pair(16'h0001, 16'h0001);
      add_pair(16'h0001, 16'hFFFF);
      add_pair(16'hFFFF, 16'h0001);
      add_pair(16'hFFFF, 16'hFFFE);
      add_pair(16'hFFFE, 16'hFFFF);
      add_pair(16'h8000, 16'h4000);
      add_pair(16'h4000, 16'h8000);
      add_pair(16'd46368, 16'd28657);
      add_pair(16'd28657, 16'd46368);
      add_pair(16'd1234, 16'd1234);
      add_pair(16'd12, 16'd18);
      add_pair(16'd65521, 16'd65519);
      add_pair(16'h5555, 16'hAAAA);

      fib.push_back(16'd1);
      fib.push_back(16'd2);
      while (fib[fib.size()-1] < 16'd40000) begin
         fib.push_back(fib[fib.size()-1] + fib[fib.size()-2]);
      end

      // random: partly pairs with shared factors or long euclid chains
      for (i = 0; i < RANDOM_PAIRS; i++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               a = FIELD_BITS'($urandom_range(0, 65535));
               b = FIELD_BITS'($urandom_range(0, 65535));
            end
            3, 4: begin
               g = FIELD_BITS'($urandom_range(1, 300));
               a = FIELD_BITS'(g * $urandom_range(0, 65535 / g));
               b = FIELD_BITS'(g * $urandom_range(0, 65535 / g));
            end
            5: begin
               a = FIELD_BITS'($urandom_range(0, 20));
               b = FIELD_BITS'($urandom_range(0, 20));
            end
            6: begin
               kind = $urandom_range(1, fib.size() - 1);
               a = fib[kind];
               b = fib[kind-1];
               if ($urandom_range(0, 1)) begin
                  g = a;
                  a = b;
                  b = g;
               end
            end
            7: begin
               a = FIELD_BITS'($urandom_range(1, 2000));
               b = FIELD_BITS'(a * $urandom_range(1, 65535 / a));
            end
            8: begin
               a = FIELD_BITS'($urandom_range(0, 65535));
               b = $urandom_range(0, 1) ? a : 16'd0;
               if ($urandom_range(0, 1)) begin
                  g = a;
                  a = b;
                  b = g;
               end
            end
            default: begin
               a = FIELD_BITS'(16'hFFFF - $urandom_range(0, 255));
               b = FIELD_BITS'(16'hFFFF - $urandom_range(0, 255));
            end
         endcase
         add_pair(a, b);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pairs_sent == pairs_total);
      wait (expected_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("gcd_lcm_unit_tb OK");
      end else begin
         $display("gcd_lcm_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/glu_pkg.sv
rtl/glu_alu.sv
rtl/glu_ctrl.sv
rtl/gcd_lcm_unit.sv
dv/gcd_lcm_unit_tb.sv
